### src/btffa_pkg.sv
`default_nettype none
package btffa_pkg;

  // item fields
  typedef struct packed {
    logic        req_type;
    logic [31:0] size_bytes;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_address;
    logic [10:0] used_blocks;
  } out_item_t;

  // configuration registers as seen by the engine
  typedef struct packed {
    logic [31:0] base_address;
    logic [10:0] blocks_in_use;
  } cfg_t;

  localparam int CFG_ADDR_W = 3;
  localparam logic [10:0] BLOCKS_RESET = 11'd1024;

  // register indexes
  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_BLOCKS = 1'b1;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // table entry flags
  localparam int ENT_W = 3;
  localparam logic [ENT_W-1:0] ENT_TAKEN     = 3'b001;
  localparam logic [ENT_W-1:0] ENT_FIRST     = 3'b010;
  localparam logic [ENT_W-1:0] ENT_HAS_NEXT  = 3'b100;
  localparam logic [ENT_W-1:0] ENT_TYPE_MASK = ENT_TAKEN & 3'(4'hF);

endpackage
`default_nettype wire

### src/block_table_first_fit_allocator.sv
// first-fit block table allocator
// input channel: an item (in_item) is taken at a rising edge with start high and
//   busy low; req_type selects allocate (size_bytes) or free (address)
// result channel: one result per item, shown on out_item for exactly one cycle
//   with out_valid high; the receiver cannot stall, so nothing is held back
// config: apb-style port, base_address at 0x0, blocks_in_use at 0x4; write
//   only while idle; pready is tied high
// timing: the block table lives in one synchronous ram read one entry a
//   cycle, so the first-fit scan is set by that read port
//   allocate: entries are read up to the end of the first free run of the
//   needed length (at most the heap length), then each block of that run
//   is marked; with no fitting run the whole heap is read before the answer
//   free: the chain is walked, each block cleared, until an entry without a
//   successor or the heap end; rejected requests are answered from idle
//   one item at a time; busy stays high until its result is shown, but a
//   rejected request is answered without raising busy
// reset: a clearing pass writes every table entry free with busy high;
//   configuration writes are taken meanwhile
// BLOCK_BYTES must be a power of two
`default_nettype none
module block_table_first_fit_allocator
  import btffa_pkg::*;
#(
  parameter int BLOCK_BYTES = 4096,
  parameter int MAX_BLOCKS  = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // item in
  input  wire logic                  start,
  output      logic                  busy,
  input  wire in_item_t              in_item,
  // result out
  output      logic                  out_valid,
  output      out_item_t             out_item,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready
);

  cfg_t cfg;

  // register file
  btffa_apb u_apb (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // scan / mark / free sequencer around the table ram
  btffa_engine #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

### src/btffa_ram.sv
`default_nettype none
module btffa_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/btffa_apb.sv
`default_nettype none
module btffa_apb
  import btffa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready,
  output      cfg_t                  cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address  <= 32'd0;
      cfg_r.blocks_in_use <= BLOCKS_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_BASE:   cfg_r.base_address  <= pwdata;
        REG_BLOCKS: cfg_r.blocks_in_use <= pwdata[10:0];
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BASE:   prdata = cfg_r.base_address;
      REG_BLOCKS: prdata = {21'd0, cfg_r.blocks_in_use};
      default:    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

### src/btffa_engine.sv
`default_nettype none
module btffa_engine
  import btffa_pkg::*;
#(
  parameter int BLOCK_BYTES = 4096,
  parameter int MAX_BLOCKS  = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      start,
  input  wire in_item_t  in_item,
  output      logic      busy,
  output      logic      out_valid,
  output      out_item_t out_item
);

  localparam int AW   = $clog2(MAX_BLOCKS);
  localparam int IW   = $clog2(MAX_BLOCKS + 1);
  localparam int LOG2 = $clog2(BLOCK_BYTES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] iss_r, iss_nxt;
  logic          pv_r, pv_nxt;
  logic [IW-1:0] chk_r, chk_nxt;
  logic [IW-1:0] run_r, run_nxt;
  logic [IW-1:0] start_r, start_nxt;
  logic [IW-1:0] need_r, need_nxt;
  logic [IW-1:0] mk_r, mk_nxt;
  logic [IW-1:0] rem_r, rem_nxt;
  logic [IW-1:0] taken_r, taken_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [ENT_W-1:0] wdata, rdata;

  logic [31:0]   n32, base_eff, blk;
  logic [IW-1:0] n, run_inc, st, t_dec;
  logic [32:0]   need33;

  btffa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // effective heap length and block-aligned base
  assign n32      = (32'(cfg.blocks_in_use) < 32'(MAX_BLOCKS)) ?
                    32'(cfg.blocks_in_use) : 32'(MAX_BLOCKS);
  assign n        = n32[IW-1:0];
  assign base_eff = cfg.base_address & ~32'(BLOCK_BYTES - 1);
  assign need33   = ({1'b0, in_item.size_bytes} + 33'(BLOCK_BYTES - 1)) >> LOG2;
  assign blk      = (in_item.address - base_eff) >> LOG2;
  assign run_inc  = run_r + 1'b1;
  assign st       = (run_r == '0) ? chk_r : start_r;
  assign t_dec    = (((rdata & ENT_TAKEN) != '0) && (taken_r != '0)) ?
                    taken_r - 1'b1 : taken_r;

  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    pv_nxt        = pv_r;
    chk_nxt       = chk_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    need_nxt      = need_r;
    mk_nxt        = mk_r;
    rem_nxt       = rem_r;
    taken_nxt     = taken_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = iss_r[AW-1:0];
    wdata         = '0;
    re            = 1'b0;
    raddr         = iss_r[AW-1:0];

    case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        iss_nxt = iss_r + 1'b1;
        if (iss_r == IW'(MAX_BLOCKS - 1)) begin
          iss_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          out_nxt.block_address = 32'd0;
          out_nxt.used_blocks   = 11'(taken_r);
          iss_nxt = '0;
          pv_nxt  = 1'b0;
          run_nxt = '0;
          if (in_item.req_type == REQ_ALLOC) begin
            if (in_item.size_bytes == 32'd0 || need33 > 33'(n)) begin
              out_valid_nxt  = 1'b1;
              out_nxt.status = ST_NOMEM;
            end else begin
              need_nxt  = need33[IW-1:0];
              state_nxt = S_SCAN;
            end
          end else begin
            if (in_item.address < base_eff || blk >= 32'(n)) begin
              out_valid_nxt  = 1'b1;
              out_nxt.status = ST_RANGE;
            end else begin
              iss_nxt   = blk[IW-1:0];
              state_nxt = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        pv_nxt = 1'b0;
        if (iss_r < n) begin
          re      = 1'b1;
          pv_nxt  = 1'b1;
          chk_nxt = iss_r;
          iss_nxt = iss_r + 1'b1;
        end
        if (pv_r) begin
          if ((rdata & ENT_TYPE_MASK) != '0) begin
            run_nxt = '0;
          end else begin
            start_nxt = st;
            run_nxt   = run_inc;
            if (run_inc == need_r) begin
              mk_nxt    = st;
              rem_nxt   = need_r;
              pv_nxt    = 1'b0;
              state_nxt = S_MARK;
            end
          end
        end else if (iss_r >= n) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = ST_NOMEM;
          out_nxt.block_address = 32'd0;
          out_nxt.used_blocks   = 11'(taken_r);
          state_nxt             = S_IDLE;
        end
      end
      S_MARK: begin
        we    = 1'b1;
        waddr = mk_r[AW-1:0];
        wdata = ENT_TAKEN | ((rem_r == need_r) ? ENT_FIRST : '0)
                | ((rem_r != IW'(1)) ? ENT_HAS_NEXT : '0);
        mk_nxt  = mk_r + 1'b1;
        rem_nxt = rem_r - 1'b1;
        if (rem_r == IW'(1)) begin
          taken_nxt             = taken_r + need_r;
          out_valid_nxt         = 1'b1;
          out_nxt.status        = ST_OK;
          out_nxt.block_address = base_eff + (32'(start_r) << LOG2);
          out_nxt.used_blocks   = 11'(taken_r + need_r);
          state_nxt             = S_IDLE;
        end
      end
      S_FREE: begin
        pv_nxt = 1'b0;
        if (iss_r < n) begin
          re      = 1'b1;
          pv_nxt  = 1'b1;
          chk_nxt = iss_r;
          iss_nxt = iss_r + 1'b1;
        end
        if (pv_r) begin
          we        = 1'b1;
          waddr     = chk_r[AW-1:0];
          taken_nxt = t_dec;
          if ((rdata & ENT_HAS_NEXT) == '0) begin
            pv_nxt                = 1'b0;
            out_valid_nxt         = 1'b1;
            out_nxt.status        = ST_OK;
            out_nxt.block_address = 32'd0;
            out_nxt.used_blocks   = 11'(t_dec);
            state_nxt             = S_IDLE;
          end
        end else if (iss_r >= n) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = ST_OK;
          out_nxt.block_address = 32'd0;
          out_nxt.used_blocks   = 11'(taken_r);
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      iss_r       <= '0;
      pv_r        <= 1'b0;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      pv_r        <= pv_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r   <= chk_nxt;
    run_r   <= run_nxt;
    start_r <= start_nxt;
    need_r  <= need_nxt;
    mk_r    <= mk_nxt;
    rem_r   <= rem_nxt;
    out_r   <= out_nxt;
  end

endmodule
`default_nettype wire

### bench/heap_checker.sv
module heap_checker
  import btffa_pkg::*;
#(
  parameter int BLOCK_BYTES = 4096,
  parameter int MAX_BLOCKS  = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  out_item_t             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output int unsigned           outstanding,
  output int unsigned           mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);

  // shadow copy of the heap
  logic [ENT_W-1:0] blk_flags [MAX_BLOCKS];
  int unsigned      taken_blocks;
  logic [31:0]      base_reg;
  logic [10:0]      blocks_reg;

  out_item_t   heap_replies_q[$];
  out_item_t   want;
  int unsigned err_cnt = 0;

  assign mismatches = err_cnt;

  function automatic out_item_t serve_request(input in_item_t req);
    out_item_t        res;
    logic [31:0]      hbase;
    logic [32:0]      need;
    int unsigned      n;
    int unsigned      run;
    int unsigned      first;
    int unsigned      blk;
    logic [ENT_W-1:0] ent;
    hbase = base_reg & ~32'(BLOCK_BYTES - 1);
    n     = (blocks_reg > MAX_BLOCKS) ? MAX_BLOCKS : blocks_reg;
    run   = 0;
    first = 0;
    res.status        = ST_OK;
    res.block_address = '0;
    if (req.req_type == REQ_ALLOC) begin
      need = ({1'b0, req.size_bytes} + 33'(BLOCK_BYTES - 1)) >> BLK_SHIFT;
      if (req.size_bytes == '0 || need > n) begin
        res.status = ST_NOMEM;
      end else begin
        // first-fit search for a run of free entries
        for (int i = 0; i < n; i++) begin
          if ((blk_flags[i] & ENT_TYPE_MASK) != '0) begin
            run = 0;
          end else begin
            if (run == 0) first = i;
            run++;
            if (run == need) break;
          end
        end
        if (run != need) begin
          res.status = ST_NOMEM;
        end else begin
          for (int i = 0; i < need; i++) begin
            ent = ENT_TAKEN;
            if (i == 0) ent |= ENT_FIRST;
            if (i + 1 != need) ent |= ENT_HAS_NEXT;
            blk_flags[first + i] = ent;
          end
          taken_blocks += 32'(need);
          res.block_address = hbase + 32'(first << BLK_SHIFT);
        end
      end
    end else begin
      if (req.address < hbase) begin
        res.status = ST_RANGE;
      end else begin
        blk = (req.address - hbase) >> BLK_SHIFT;
        if (blk >= n) begin
          res.status = ST_RANGE;
        end else begin
          // walk the chain until an entry without a successor
          for (int i = blk; i < n; i++) begin
            ent = blk_flags[i];
            blk_flags[i] = '0;
            if ((ent & ENT_TAKEN) != '0 && taken_blocks > 0) taken_blocks--;
            if ((ent & ENT_HAS_NEXT) == '0) break;
          end
        end
      end
    end
    res.used_blocks = taken_blocks[10:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BLOCKS; i++) blk_flags[i] = '0;
      taken_blocks = 0;
      base_reg     = '0;
      blocks_reg   = BLOCKS_RESET;
      heap_replies_q.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[CFG_ADDR_W-1:2] == REG_BASE) begin
          base_reg = pwdata;
        end else if (paddr[CFG_ADDR_W-1:2] == REG_BLOCKS) begin
          blocks_reg = pwdata[10:0];
        end
      end
      if (out_valid) begin
        if (heap_replies_q.size() == 0) begin
          $display("%0t: unexpected result, got status %0d addr %h used %0d",
                   $time, out_item.status, out_item.block_address, out_item.used_blocks);
          err_cnt++;
        end else begin
          want = heap_replies_q.pop_front();
          if (want !== out_item) begin
            $display("%0t: result mismatch, expected status %0d addr %h used %0d",
                     $time, want.status, want.block_address, want.used_blocks);
            $display("%0t:                   got status %0d addr %h used %0d",
                     $time, out_item.status, out_item.block_address, out_item.used_blocks);
            err_cnt++;
          end
        end
      end
      if (start && !busy) heap_replies_q.push_back(serve_request(in_item));
      outstanding <= heap_replies_q.size();
    end
  end

endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btffa_pkg::*;

  localparam int BLOCK_BYTES    = 4096;
  localparam int MAX_BLOCKS     = 1024;
  localparam int BLK_SHIFT      = $clog2(BLOCK_BYTES);
  // longest quiet spell: clearing pass, or a full scan plus marking of the table
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 2200;

  // a run handed out by the allocator, in blocks from the heap base
  typedef struct packed {
    logic [31:0] idx;
    logic [31:0] nblk;
  } run_t;

  // what was sent, so the returned address can be filed once it shows up
  typedef struct packed {
    logic        is_alloc;
    logic [31:0] nblk;
  } sent_t;

  logic                  clk;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int unsigned outstanding;
  int unsigned mismatches;

  run_t        live_runs[$];
  sent_t       sent_q[$];
  logic [31:0] cur_hbase    = '0;
  int unsigned cur_n        = MAX_BLOCKS;
  bit          no_idle      = 1'b0;
  int unsigned stall_cycles = 0;

  block_table_first_fit_allocator #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  heap_checker #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // file each successful allocation so later frees can target real runs;
  // one item in flight at a time, so results pair with sent_q in order
  always @(posedge clk) begin
    sent_t note;
    if (out_valid && sent_q.size() != 0) begin
      note = sent_q.pop_front();
      if (note.is_alloc && out_item.status == ST_OK) begin
        live_runs.push_back('{idx: (out_item.block_address - cur_hbase) >> BLK_SHIFT,
                              nblk: note.nblk});
      end
    end
  end

  // watchdog: cycles with neither an item taken nor a result shown
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t alloc_item(input logic [31:0] size);
    in_item_t req;
    req.req_type   = REQ_ALLOC;
    req.size_bytes = size;
    req.address    = $urandom;   // unused on allocate, toggled anyway
    return req;
  endfunction

  function automatic in_item_t free_item(input logic [31:0] addr);
    in_item_t req;
    req.req_type   = REQ_FREE;
    req.size_bytes = $urandom;   // unused on free
    req.address    = addr;
    return req;
  endfunction

  // offer one item and hold it until the block takes it;
  // start is left high so back-to-back items keep it asserted
  task automatic push_request(input in_item_t req);
    sent_t       note;
    logic [32:0] need;
    if (!no_idle && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    need          = ({1'b0, req.size_bytes} + 33'(BLOCK_BYTES - 1)) >> BLK_SHIFT;
    note.is_alloc = (req.req_type == REQ_ALLOC);
    note.nblk     = need[31:0];
    sent_q.push_back(note);
  endtask

  // stop offering items until every result is back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // setup cycle then access cycle; the write lands when pready is seen
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // reconfigure only once the block has gone quiet
  task automatic set_heap(input logic [31:0] base, input logic [10:0] blocks);
    wait_drained();
    write_reg(REG_BASE, base);
    write_reg(REG_BLOCKS, {21'b0, blocks});
    cur_hbase = base & ~32'(BLOCK_BYTES - 1);
    cur_n     = (blocks > MAX_BLOCKS) ? MAX_BLOCKS : blocks;
  endtask

  // mostly alloc/free traffic on real runs, with some stray frees and noise
  task automatic random_request();
    int unsigned r;
    int unsigned j;
    int unsigned hi;
    int unsigned need;
    int unsigned off;
    run_t        pick;
    logic [31:0] addr;
    in_item_t    req;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      // raw noise over every bit of every field
      req.req_type   = 1'($urandom_range(0, 1));
      req.size_bytes = $urandom;
      req.address    = $urandom;
    end else if (r < 20) begin
      // free of any block in the heap, or just past it: non-first, free or taken
      addr = cur_hbase + (32'($urandom_range(0, cur_n)) << BLK_SHIFT)
             + $urandom_range(0, BLOCK_BYTES - 1);
      req = free_item(addr);
    end else if (live_runs.size() == 0 || r < 60) begin
      hi   = (cur_n / 6 > 1) ? cur_n / 6 : 1;
      need = $urandom_range(1, hi);
      // now and then ask for the whole heap, or one block more
      if ($urandom_range(0, 19) == 0) need = cur_n + $urandom_range(0, 1);
      if (need == 0) req = alloc_item('0);
      else req = alloc_item(32'((need - 1) * BLOCK_BYTES) + $urandom_range(1, BLOCK_BYTES));
    end else begin
      j    = $urandom_range(0, live_runs.size() - 1);
      pick = live_runs[j];
      off  = $urandom_range(0, 9);
      if (off < 7) begin
        // proper release of a run, anywhere inside its first block
        addr = cur_hbase + (pick.idx << BLK_SHIFT) + $urandom_range(0, BLOCK_BYTES - 1);
        live_runs.delete(j);
      end else if (off < 9 && pick.nblk > 1) begin
        // cut the tail off a run from a middle block
        off  = $urandom_range(1, pick.nblk - 1);
        addr = cur_hbase + ((pick.idx + off) << BLK_SHIFT);
        live_runs[j].nblk = off;
      end else begin
        // released but left listed, so a double free follows later
        addr = cur_hbase + (pick.idx << BLK_SHIFT);
      end
      req = free_item(addr);
    end
    push_request(req);
  endtask

  initial begin
    logic [31:0] base;
    logic [10:0] blocks;
    int unsigned count;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: base with stray low bits, full-size heap
    set_heap(32'h1000_0ABC, 11'd1024);
    push_request(alloc_item(32'd0));                       // zero size
    push_request(alloc_item(32'd1));                       // block 0
    push_request(alloc_item(32'd4096));                    // exactly one block
    push_request(alloc_item(32'd4097));                    // rounds up to two
    push_request(alloc_item(32'hFFFF_FFFF));               // larger than the heap
    push_request(alloc_item(32'(MAX_BLOCKS * BLOCK_BYTES))); // fits size, no free run
    push_request(free_item(32'd0));                        // below the base
    push_request(free_item(cur_hbase + 32'(MAX_BLOCKS * BLOCK_BYTES))); // past the end
    push_request(free_item(32'hFFFF_FFFF));
    push_request(free_item(cur_hbase + 32'(3 * BLOCK_BYTES) + 32'd5)); // tail of a run
    push_request(free_item(cur_hbase + 32'(500 * BLOCK_BYTES)));       // already free
    push_request(free_item(cur_hbase + 32'(2 * BLOCK_BYTES)));         // head, tail gone
    push_request(free_item(cur_hbase + 32'd4095));
    push_request(free_item(cur_hbase + 32'(BLOCK_BYTES)));
    push_request(alloc_item(32'(MAX_BLOCKS * BLOCK_BYTES)));           // whole heap
    push_request(alloc_item(32'd1));                                   // heap full
    push_request(free_item(cur_hbase + 32'((MAX_BLOCKS - 1) * BLOCK_BYTES)));
    push_request(alloc_item(32'(BLOCK_BYTES)));                        // refills last
    push_request(free_item(cur_hbase + 32'(12 * BLOCK_BYTES) + 32'd7)); // mid-run walk
    push_request(free_item(cur_hbase));

    // top of the address space: the second run wraps past zero
    set_heap(32'hFFFF_FFFF, 11'd16);
    push_request(alloc_item(32'(2 * BLOCK_BYTES)));
    push_request(alloc_item(32'(2 * BLOCK_BYTES)));
    push_request(free_item(32'h0000_1000));                // wrapped, so below base
    push_request(free_item(cur_hbase));

    // empty heap
    set_heap(32'd0, 11'd0);
    push_request(alloc_item(32'd1));
    push_request(free_item(32'd0));

    wait_drained();
    live_runs.delete();

    // random phases over a spread of heap settings; the table carries over
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin base = $urandom;       blocks = 11'd1024; count = 90;  end
        1: begin base = 32'd0;          blocks = 11'd64;   count = 80;  end
        2: begin base = 32'hFFFF_FFFF;  blocks = 11'd16;   count = 60;  end
        3: begin base = $urandom;       blocks = 11'd1;    count = 30;  end
        4: begin base = $urandom;       blocks = 11'd2047; count = 80;  end
        5: begin base = $urandom;       blocks = 11'd0;    count = 15;  end
        6: begin base = $urandom;       blocks = 11'($urandom_range(2, 200)); count = 100; end
        default: begin base = $urandom; blocks = 11'd32;   count = 100; end
      endcase
      no_idle = (ph == 6);   // one long stretch with the sender never idle
      set_heap(base, blocks);
      if (ph != 3 && ph != 4) live_runs.delete();  // stale run positions
      for (int k = 0; k < count; k++) begin
        if (ph == 7 && k == 50) wait_drained();    // hold off until all is back
        random_request();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### block_table_first_fit_allocator.f
src/btffa_pkg.sv
src/btffa_ram.sv
src/btffa_apb.sv
src/btffa_engine.sv
src/block_table_first_fit_allocator.sv
bench/heap_checker.sv
bench/tb_top.sv
